// File: rtl/npcs_pkg.sv
// shared types and constants for the nearest palette colour search
// no dependencies
`default_nettype none

package npcs_pkg;

  localparam int unsigned PALETTE_ENTRIES_DEF = 256;
  localparam int unsigned IDX_W   = 8;
  localparam int unsigned CHAN_W  = 8;
  localparam int unsigned SQ_W    = 2 * CHAN_W;
  localparam int unsigned DIST_W  = SQ_W + 2;

  localparam logic [DIST_W-1:0] DIST_THRESHOLD = DIST_W'(32'h0001_0000);

  localparam logic CMD_WRITE = 1'b0;
  localparam logic CMD_QUERY = 1'b1;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
  } rgb_t;

  typedef struct packed {
    logic             vld;
    logic             last;
    logic [IDX_W-1:0] idx;
  } scan_tag_t;

endpackage

`default_nettype wire

// File: rtl/npcs_if.sv
// valid/ready channel interfaces for command and result beats
// depends on npcs_pkg
`default_nettype none

interface npcs_in_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [npcs_pkg::IDX_W-1:0]  entry_index;
  logic [npcs_pkg::CHAN_W-1:0] red;
  logic [npcs_pkg::CHAN_W-1:0] green;
  logic [npcs_pkg::CHAN_W-1:0] blue;

  modport source (output valid, cmd, entry_index, red, green, blue, input ready);
  modport sink   (input valid, cmd, entry_index, red, green, blue, output ready);
endinterface

interface npcs_out_if;
  logic                       valid;
  logic                       ready;
  logic [npcs_pkg::IDX_W-1:0] nearest_index;

  modport source (output valid, nearest_index, input ready);
  modport sink   (input valid, nearest_index, output ready);
endinterface

`default_nettype wire

// File: rtl/npcs_palette_mem.sv
// palette storage: one write port, one read port, registered read data
// depends on npcs_pkg
`default_nettype none

module npcs_palette_mem #(
  parameter int unsigned ENTRIES = npcs_pkg::PALETTE_ENTRIES_DEF,
  parameter int unsigned AW      = $clog2(ENTRIES)
) (
  input  logic                 clk_i,
  input  logic                 we_i,
  input  logic [AW-1:0]        waddr_i,
  input  npcs_pkg::rgb_t       wdata_i,
  input  logic                 re_i,
  input  logic [AW-1:0]        raddr_i,
  output npcs_pkg::rgb_t       rdata_o
);
  import npcs_pkg::*;

  rgb_t mem_q [ENTRIES];
  rgb_t rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: rtl/npcs_dist.sv
// two-stage squared euclidean distance between a palette entry and the query
// depends on npcs_pkg
`default_nettype none

module npcs_dist (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  npcs_pkg::scan_tag_t           tag_i,
  input  npcs_pkg::rgb_t                entry_i,
  input  npcs_pkg::rgb_t                query_i,
  output npcs_pkg::scan_tag_t           tag_o,
  output logic [npcs_pkg::DIST_W-1:0]   dist_o
);
  import npcs_pkg::*;

  logic [CHAN_W-1:0] dr, dg, db;
  logic [SQ_W-1:0]   sq_r_q, sq_g_q, sq_b_q;
  logic [DIST_W-1:0] dist_q;
  scan_tag_t         tag1_q, tag2_q;

  always_comb begin
    dr = (query_i.red   >= entry_i.red)   ? query_i.red   - entry_i.red
                                          : entry_i.red   - query_i.red;
    dg = (query_i.green >= entry_i.green) ? query_i.green - entry_i.green
                                          : entry_i.green - query_i.green;
    db = (query_i.blue  >= entry_i.blue)  ? query_i.blue  - entry_i.blue
                                          : entry_i.blue  - query_i.blue;
  end

  // stage 1: squares
  always_ff @(posedge clk_i) begin
    sq_r_q <= SQ_W'(dr) * SQ_W'(dr);
    sq_g_q <= SQ_W'(dg) * SQ_W'(dg);
    sq_b_q <= SQ_W'(db) * SQ_W'(db);
  end

  // stage 2: sum
  always_ff @(posedge clk_i) begin
    dist_q <= DIST_W'(sq_r_q) + DIST_W'(sq_g_q) + DIST_W'(sq_b_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
      tag2_q <= '0;
    end else begin
      tag1_q <= tag_i;
      tag2_q <= tag1_q;
    end
  end

  assign tag_o  = tag2_q;
  assign dist_o = dist_q;

endmodule

`default_nettype wire

// File: rtl/nearest_palette_colour_search.sv
// top level: command decode, palette scan sequencer, best-match compare, result register
// depends on npcs_pkg, npcs_if, npcs_palette_mem, npcs_dist
`default_nettype none

// A write beat stores one RGB entry in the palette memory; writes to an index at or above
// PALETTE_ENTRIES are dropped. A query beat scans the whole palette through the memory's
// single read port, one entry per cycle, and returns the lowest index with the smallest
// squared distance below 65536, with index 0 or no match reported as index 1. A query passes
// through the scan, the memory read, the two distance stages, the compare and the result load.
// Input is taken only between queries, but the next beat is taken while a result still
// waits in the output register. Every entry must be written before the first query.
module nearest_palette_colour_search #(
  parameter int unsigned PALETTE_ENTRIES = npcs_pkg::PALETTE_ENTRIES_DEF
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  npcs_in_if.sink           in_i,
  npcs_out_if.source        out_o
);
  import npcs_pkg::*;

  localparam int unsigned AW = $clog2(PALETTE_ENTRIES);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_DONE  = 2'd3;

  logic [1:0]        state_q, state_d;
  logic [AW-1:0]     addr_q, addr_d;
  rgb_t              query_q;
  logic [DIST_W-1:0] best_q, best_d;
  logic [IDX_W-1:0]  best_idx_q, best_idx_d;
  logic              out_vld_q, out_vld_d;
  logic [IDX_W-1:0]  out_idx_q, out_idx_d;
  scan_tag_t         rd_tag_q, rd_tag_d;
  scan_tag_t         dist_tag;
  logic [DIST_W-1:0] entry_dist;
  rgb_t              wdata, rdata;
  logic              in_beat, wr_en, rd_en, addr_last;

  assign in_i.ready = (state_q == ST_IDLE);
  assign in_beat    = in_i.valid && in_i.ready;
  assign wr_en      = in_beat && (in_i.cmd == CMD_WRITE)
                      && ({1'b0, in_i.entry_index} < 9'(PALETTE_ENTRIES));
  assign wdata      = '{red: in_i.red, green: in_i.green, blue: in_i.blue};
  assign rd_en      = (state_q == ST_SCAN);
  assign addr_last  = (addr_q == AW'(PALETTE_ENTRIES - 1));

  npcs_palette_mem #(
    .ENTRIES (PALETTE_ENTRIES),
    .AW      (AW)
  ) u_mem (
    .clk_i   (clk_i),
    .we_i    (wr_en),
    .waddr_i (in_i.entry_index[AW-1:0]),
    .wdata_i (wdata),
    .re_i    (rd_en),
    .raddr_i (addr_q),
    .rdata_o (rdata)
  );

  npcs_dist u_dist (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .tag_i   (rd_tag_q),
    .entry_i (rdata),
    .query_i (query_q),
    .tag_o   (dist_tag),
    .dist_o  (entry_dist)
  );

  always_comb begin
    state_d    = state_q;
    addr_d     = addr_q;
    best_d     = best_q;
    best_idx_d = best_idx_q;
    out_vld_d  = out_vld_q;
    out_idx_d  = out_idx_q;
    rd_tag_d   = '{vld: rd_en, last: addr_last, idx: IDX_W'(addr_q)};

    if (out_vld_q && out_o.ready) begin
      out_vld_d = 1'b0;
    end

    if (dist_tag.vld && (entry_dist < best_q)) begin
      best_d     = entry_dist;
      best_idx_d = dist_tag.idx;
    end

    unique case (state_q)
      ST_IDLE: begin
        if (in_beat && (in_i.cmd == CMD_QUERY)) begin
          state_d    = ST_SCAN;
          addr_d     = '0;
          best_d     = DIST_THRESHOLD;
          best_idx_d = '0;
        end
      end
      ST_SCAN: begin
        addr_d = addr_q + AW'(1);
        if (addr_last) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (dist_tag.vld && dist_tag.last) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!out_vld_q || out_o.ready) begin
          out_vld_d = 1'b1;
          out_idx_d = (best_idx_q == '0) ? IDX_W'(1) : best_idx_q;
          state_d   = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      out_vld_q <= 1'b0;
      rd_tag_q  <= '0;
    end else begin
      state_q   <= state_d;
      out_vld_q <= out_vld_d;
      rd_tag_q  <= rd_tag_d;
    end
  end

  always_ff @(posedge clk_i) begin
    addr_q     <= addr_d;
    best_q     <= best_d;
    best_idx_q <= best_idx_d;
    out_idx_q  <= out_idx_d;
    if (in_beat && (in_i.cmd == CMD_QUERY)) begin
      query_q <= wdata;
    end
  end

  assign out_o.valid         = out_vld_q;
  assign out_o.nearest_index = out_idx_q;

endmodule

`default_nettype wire
